// ----- design/vht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vht_pkg: shared types and constants of the virtual handle table.
// Request and response formats, command codes and the control interface
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package vht_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_ALLOC  = 2'd3
  } command_t;

  // Configuration register indexes.
  localparam logic CFG_HDL_CLASS   = 1'b0;
  localparam logic CFG_ENTRY_LIMIT = 1'b1;

  localparam int HDL_CLASS_W   = 8;
  localparam int ENTRY_LIMIT_W = 7;
  localparam int CFG_DATA_W    = 8;
  localparam int COUNT_OUT_W   = 7;
  localparam int COUNTER_W     = 25;

  localparam logic [HDL_CLASS_W-1:0]   HDL_CLASS_RESET   = 8'h80;
  localparam logic [ENTRY_LIMIT_W-1:0] ENTRY_LIMIT_RESET = 7'd64;
  localparam logic [COUNTER_W-1:0]     COUNTER_START     = 25'h00000ff;
  localparam logic [COUNTER_W-1:0]     COUNTER_LIMIT     = 25'h1000000;

  typedef struct packed {
    command_t    command;
    logic [31:0] vhandle;
    logic        entry_present;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic                   ok;
    logic [31:0]            found_value;
    logic [31:0]            new_handle;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_scan;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- design/vht_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vht_ctrl: sequencing controller of the virtual handle table.
// Runs the clearing pass after reset, then steps a request through accept,
// slot scan and drain (skipped for alloc and a refused insert), completion.
// ----------------------------------------------------------------------------
module vht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  vht_pkg::ctrl_sts_t sts,
  output vht_pkg::ctrl_cmd_t cmd
);
  import vht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clear_en = (state == S_CLEAR);
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.scan_en  = (state == S_SCAN);
    cmd.finish   = (state == S_DONE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.scan_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) state <= sts.need_scan ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          if (sts.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ----- design/vht_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vht_datapath: slot memory, scan logic, counters and response register.
// Slots are read one per cycle; the compare stage tracks the matching slot
// and the lowest free slot, and completion applies the command.
// ----------------------------------------------------------------------------
module vht_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vht_pkg::req_t                   req,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [vht_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  vht_pkg::ctrl_cmd_t              cmd,
  output vht_pkg::ctrl_sts_t              sts,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output vht_pkg::rsp_t                   rsp
);
  import vht_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int UW = (CW > ENTRY_LIMIT_W) ? CW : ENTRY_LIMIT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [UW-1:0] DEPTH_U   = UW'(DEPTH);

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] tag;
  } slot_t;

  slot_t mem [DEPTH];
  slot_t rd_data;

  logic [HDL_CLASS_W-1:0]   hdl_class;
  logic [ENTRY_LIMIT_W-1:0] entry_limit;
  logic [CW-1:0]            used_count;
  logic [COUNTER_W-1:0]     next_counter;

  req_t          cur;
  logic [AW-1:0] ptr;
  logic [AW-1:0] cmp_idx;
  logic          rd_pend;
  logic          match_found;
  logic [AW-1:0] match_idx;
  logic [31:0]   match_tag;
  logic          free_found;
  logic [AW-1:0] free_idx;

  logic          full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;
  rsp_t          rsp_next;
  logic [CW-1:0] used_next;
  logic [COUNTER_W-1:0] counter_next;

  // The full test uses the live count, which only changes at completion.
  assign full = (UW'(used_count) >= UW'(entry_limit)) || (UW'(used_count) >= DEPTH_U);

  always_comb begin
    sts           = '0;
    sts.scan_last = (ptr == LAST_ADDR);
    sts.need_scan = (req.command != CMD_ALLOC) && !((req.command == CMD_INSERT) && full);
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  // Completion: apply the command and form the response.
  always_comb begin
    rsp_next     = '0;
    used_next    = used_count;
    counter_next = next_counter;
    wr_en        = 1'b0;
    wr_addr      = ptr;
    wr_data      = '0;
    unique case (cur.command)
      CMD_INSERT: begin
        if (!full) begin
          rsp_next.ok = 1'b1;
          if (cur.entry_present && (cur.vhandle != 32'd0) && !match_found && free_found) begin
            wr_en     = 1'b1;
            wr_addr   = free_idx;
            wr_data   = '{valid: 1'b1, key: cur.vhandle, tag: cur.entry_value};
            used_next = used_count + CW'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (match_found) begin
          rsp_next.ok = 1'b1;
          wr_en       = 1'b1;
          wr_addr     = match_idx;
          used_next   = used_count - CW'(1);
        end
      end
      CMD_LOOKUP: begin
        if (match_found) begin
          rsp_next.ok          = 1'b1;
          rsp_next.found_value = match_tag;
        end
      end
      CMD_ALLOC: begin
        if (next_counter < COUNTER_LIMIT) begin
          rsp_next.new_handle = {hdl_class, next_counter[23:0]};
          counter_next        = next_counter + COUNTER_W'(1);
        end
        rsp_next.ok = (rsp_next.new_handle != 32'd0);
      end
      default: begin
        rsp_next = '0;
      end
    endcase
    rsp_next.entry_count = COUNT_OUT_W'(used_next);
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = ptr;
      wr_data = '0;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en || cmd.clear_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_en) begin
      rd_data <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdl_class    <= HDL_CLASS_RESET;
      entry_limit  <= ENTRY_LIMIT_RESET;
      used_count   <= '0;
      next_counter <= COUNTER_START;
      ptr          <= '0;
      rd_pend      <= 1'b0;
      match_found  <= 1'b0;
      free_found   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HDL_CLASS:   hdl_class   <= cfg_data[HDL_CLASS_W-1:0];
          CFG_ENTRY_LIMIT: entry_limit <= cfg_data[ENTRY_LIMIT_W-1:0];
          default:         hdl_class   <= hdl_class;
        endcase
      end

      if (cmd.load) begin
        ptr <= '0;
      end else if (cmd.clear_en || cmd.scan_en) begin
        ptr <= (ptr == LAST_ADDR) ? '0 : ptr + AW'(1);
      end

      rd_pend <= cmd.scan_en;

      if (cmd.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (rd_pend) begin
        if (rd_data.valid && (rd_data.key == cur.vhandle) && !match_found) begin
          match_found <= 1'b1;
        end
        if (!rd_data.valid && !free_found) begin
          free_found <= 1'b1;
        end
      end

      if (cmd.finish) begin
        used_count   <= used_next;
        next_counter <= counter_next;
      end

      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    cmp_idx <= ptr;
    if (rd_pend && rd_data.valid && (rd_data.key == cur.vhandle) && !match_found) begin
      match_idx <= cmp_idx;
      match_tag <= rd_data.tag;
    end
    if (rd_pend && !rd_data.valid && !free_found) begin
      free_idx <= cmp_idx;
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- design/virtual_handle_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_handle_table_unit: bounded handle-to-tag table with handle allocator.
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// Insert, remove and lookup load the response register after the slot reads,
// the drain of the last read and the completion step; allocate and a refused
// insert go straight to completion. One request is in work at a time: the
// next is accepted once the last completes, which a held response can stall.
// Reset: a clearing pass marks every slot empty with requests stalled;
// configuration is taken once out of reset.
module virtual_handle_table_unit #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request channel.
  input  logic                           req_valid,
  output logic                           req_stall,
  input  vht_pkg::req_t                  req,
  // Response channel.
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output vht_pkg::rsp_t                  rsp,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [vht_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vht_pkg::*;

  // The controller only sees status flags from the datapath and drives a
  // small set of commands back. The response register sits in the datapath,
  // so a finished response may wait while the next request is accepted.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  vht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the slot memory, the compare stage that records the
  // matching slot and the lowest free slot, the entry count, the allocation
  // counter and the configuration registers.
  vht_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- dv/virtual_handle_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_handle_table_unit_tb: self-checking bench for the handle table.
// A shadow copy of the table, the allocator counter and both registers
// predicts the response to every accepted request. Responses are compared
// field by field, in order. The run starts with a directed pass over the
// special cases and then goes through random phases with different register
// settings, sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module virtual_handle_table_unit_tb;
  import vht_pkg::*;

  localparam int SLOTS        = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int POOL_SIZE    = 80;

  // Shadow of the table. note_request applies one accepted request and
  // queues the response it must produce; check_response pops the oldest.
  class vht_shadow_table;
    bit              slot_used[SLOTS];
    logic [31:0]     slot_key[SLOTS];
    logic [31:0]     slot_tag[SLOTS];
    int unsigned     used_count;
    logic [COUNTER_W-1:0]     alloc_counter;
    logic [HDL_CLASS_W-1:0]   hdl_class;
    logic [ENTRY_LIMIT_W-1:0] entry_limit;
    rsp_t            replies_due[$];
    int              mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      used_count    = 0;
      alloc_counter = COUNTER_START;
      hdl_class     = HDL_CLASS_RESET;
      entry_limit   = ENTRY_LIMIT_RESET;
      mismatches    = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    function void write_register(input logic idx, input logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_HDL_CLASS) hdl_class = value[HDL_CLASS_W-1:0];
      else entry_limit = value[ENTRY_LIMIT_W-1:0];
    endfunction

    function int find_key(input logic [31:0] key);
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < SLOTS; i++)
        if (!slot_used[i]) return i;
      return -1;
    endfunction

    function void note_request(input req_t r);
      rsp_t reply;
      int   idx;
      reply = '0;
      case (r.command)
        CMD_INSERT: begin
          // Refused once the count reaches the register or the slot count.
          if (used_count < entry_limit && used_count < SLOTS) begin
            reply.ok = 1'b1;
            if (r.entry_present && r.vhandle != 0 && find_key(r.vhandle) < 0) begin
              idx = find_free();
              if (idx >= 0) begin
                slot_used[idx] = 1'b1;
                slot_key[idx]  = r.vhandle;
                slot_tag[idx]  = r.entry_value;
                used_count++;
              end
            end
          end
        end
        CMD_REMOVE: begin
          idx = find_key(r.vhandle);
          if (idx >= 0) begin
            slot_used[idx] = 1'b0;
            used_count--;
            reply.ok = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          idx = find_key(r.vhandle);
          if (idx >= 0) begin
            reply.found_value = slot_tag[idx];
            reply.ok = 1'b1;
          end
        end
        default: begin
          if (alloc_counter < COUNTER_LIMIT) begin
            reply.new_handle = {hdl_class, 24'h0} + 32'(alloc_counter);
            alloc_counter++;
          end
          reply.ok = (reply.new_handle != 0);
        end
      endcase
      reply.entry_count = used_count[COUNT_OUT_W-1:0];
      replies_due.push_back(reply);
    endfunction

    task check_response(input rsp_t got);
      rsp_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("response %h arrived with no request outstanding", got));
        return;
      end
      want = replies_due.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %b want %b", got.ok, want.ok));
      if (got.found_value !== want.found_value)
        report($sformatf("found_value got %h want %h", got.found_value, want.found_value));
      if (got.new_handle !== want.new_handle)
        report($sformatf("new_handle got %h want %h", got.new_handle, want.new_handle));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count got %0d want %0d", got.entry_count, want.entry_count));
    endtask

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req       = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = CFG_HDL_CLASS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  vht_shadow_table shadow;
  int              sender_idle_pct = 0;
  int              rsp_stall_pct   = 0;
  logic            hold_active     = 1'b0;
  int              cycle_count     = 0;
  logic [31:0]     key_pool[POOL_SIZE];
  event            hold_trigger;

  virtual_handle_table_unit #(.DEPTH(SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Timeout guard: generous against the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: responses are sampled at the edge with the values that held
  // before it; the stall for the next cycle is chosen afterwards.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) shadow.check_response(rsp);
    if (hold_active) rsp_stall <= 1'b1;
    else rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps offering
  // requests while the block backs up and stalls its input.
  always begin
    @(hold_trigger);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  function automatic req_t make_req(input command_t cmd, input logic [31:0] key,
                                    input logic present, input logic [31:0] tag);
    req_t r;
    r.command       = cmd;
    r.vhandle       = key;
    r.entry_present = present;
    r.entry_value   = tag;
    return r;
  endfunction

  // Keys mostly come from the first span entries of a pool, so inserts,
  // lookups and removes keep hitting stored entries; the rest are zero or
  // fresh random keys. A small share of requests is pure noise.
  function automatic req_t random_request(input int span, input int insert_pct);
    req_t r;
    int   roll;
    int   pick;
    r.vhandle       = $urandom;
    r.entry_present = ($urandom_range(9) != 0);
    r.entry_value   = $urandom;
    if ($urandom_range(99) < 5) begin
      r.command       = command_t'($urandom_range(3));
      r.entry_present = 1'($urandom_range(1));
      return r;
    end
    roll = $urandom_range(99);
    if (roll < insert_pct) r.command = CMD_INSERT;
    else begin
      pick = $urandom_range(9);
      if (pick < 3) r.command = CMD_REMOVE;
      else if (pick < 7) r.command = CMD_LOOKUP;
      else r.command = CMD_ALLOC;
    end
    roll = $urandom_range(99);
    if (roll < 5) r.vhandle = '0;
    else if (roll >= 12) r.vhandle = key_pool[$urandom_range(span - 1)];
    return r;
  endfunction

  // Offers one request and returns at the edge that accepts it. Valid stays
  // high afterwards; drain_table lowers it, as does the next call when it idles.
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    shadow.note_request(r);
  endtask

  task automatic drain_table();
    req_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    shadow.write_register(idx, value);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int span, input int insert_pct,
                           input int send_pct, input int recv_pct);
    sender_idle_pct = send_pct;
    rsp_stall_pct  <= recv_pct;
    repeat (count) send_request(random_request(span, insert_pct));
    drain_table();
  endtask

  initial begin
    shadow = new();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h8000_0000;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at the reset register values.
    send_request(make_req(CMD_ALLOC,  32'h0,         1'b0, 32'h0));
    send_request(make_req(CMD_INSERT, 32'h0,         1'b1, 32'hDEAD_0000)); // zero key
    send_request(make_req(CMD_INSERT, 32'h11,        1'b0, 32'h1111));      // no entry
    send_request(make_req(CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_request(make_req(CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h1234));      // duplicate
    send_request(make_req(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0));
    send_request(make_req(CMD_INSERT, 32'h1,         1'b1, 32'h0));
    send_request(make_req(CMD_LOOKUP, 32'h1,         1'b1, 32'hFFFF_FFFF));
    send_request(make_req(CMD_LOOKUP, 32'h0,         1'b0, 32'h0));
    send_request(make_req(CMD_LOOKUP, 32'h22,        1'b0, 32'h0));
    send_request(make_req(CMD_REMOVE, 32'h0,         1'b0, 32'h0));
    send_request(make_req(CMD_REMOVE, 32'h22,        1'b0, 32'h0));
    send_request(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0));
    // The freed lowest slot must be reused.
    send_request(make_req(CMD_INSERT, 32'h8000_0000, 1'b1, 32'h1));
    send_request(make_req(CMD_LOOKUP, 32'h8000_0000, 1'b0, 32'h0));
    send_request(make_req(CMD_REMOVE, 32'h1,         1'b0, 32'h0));
    send_request(make_req(CMD_ALLOC,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    drain_table();

    // Full table: one entry held with a limit of one, then a limit of zero.
    write_register(CFG_ENTRY_LIMIT, 8'd1);
    send_request(make_req(CMD_INSERT, 32'h5,         1'b1, 32'h55));
    send_request(make_req(CMD_LOOKUP, 32'h5,         1'b0, 32'h0));
    send_request(make_req(CMD_REMOVE, 32'h8000_0000, 1'b0, 32'h0));
    send_request(make_req(CMD_INSERT, 32'h5,         1'b1, 32'h55));
    drain_table();
    write_register(CFG_ENTRY_LIMIT, 8'd0);
    send_request(make_req(CMD_INSERT, 32'h6,         1'b1, 32'h66));
    send_request(make_req(CMD_ALLOC,  32'h0,         1'b0, 32'h0));
    drain_table();

    // Counter exhaustion needs about 2^24 allocations and lies beyond the run.

    write_register(CFG_HDL_CLASS, 8'h00);
    write_register(CFG_ENTRY_LIMIT, 8'd5);
    run_phase(150, 10, 45, 0, 0);

    // Insert-heavy with the full slot count, so the table fills up.
    write_register(CFG_HDL_CLASS, 8'hFF);
    write_register(CFG_ENTRY_LIMIT, 8'd64);
    run_phase(250, POOL_SIZE, 65, 82, 0);

    // Limit above the slot count is capped by the slots.
    write_register(CFG_HDL_CLASS, 8'h5A);
    write_register(CFG_ENTRY_LIMIT, 8'hFF);
    run_phase(200, POOL_SIZE, 40, 0, 82);

    // Bit seven of the write data is dropped: the limit becomes 40.
    write_register(CFG_HDL_CLASS, 8'h80);
    write_register(CFG_ENTRY_LIMIT, 8'hA8);
    -> hold_trigger;
    run_phase(150, 60, 50, 31, 31);

    write_register(CFG_HDL_CLASS, 8'h01);
    write_register(CFG_ENTRY_LIMIT, 8'd0);
    run_phase(60, 60, 30, 0, 0);

    write_register(CFG_ENTRY_LIMIT, 8'd2);
    run_phase(120, 6, 45, 31, 31);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.pending() != 0)
      shadow.report($sformatf("%0d responses never arrived", shadow.pending()));
    if (shadow.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
